// ===== hdl/swsnd_pkg.sv =====
// Shared types, codes and width helpers for the sliding window sender.
// Used by every module under hdl; depends on nothing else.
package swsnd_pkg;

  // Default window depth
  localparam int WINDOW_MAX_DEF = 8;

  // Operation codes of a request
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_SENT   = 2'd0;
  localparam logic [1:0] KIND_RESENT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_ACKED  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW_LIMIT = 2'd0;
  localparam logic [1:0] REG_TIMEOUT      = 2'd1;
  localparam logic [1:0] REG_INIT_SEQ     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [3:0]  WINDOW_LIMIT_RST = 4'd8;
  localparam logic [31:0] TIMEOUT_RST      = 32'd3;
  localparam logic [30:0] INIT_SEQ_RST     = 31'd0;

  // A frame counts as acknowledged when the distance lies in 1 .. HALF_SEQ
  localparam logic [30:0] HALF_SEQ = 31'h4000_0000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEND,
    S_ACK,
    S_TICK
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] payload_handle;
    logic [30:0] ack_next_seq;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] frame_seq;
    logic [15:0] frame_payload;
    logic [3:0]  freed_count;
    logic        last;
  } rsp_t;

  // One window slot as held in the slot memory
  typedef struct packed {
    logic [30:0] seq;
    logic [15:0] payload;
    logic [31:0] stamp;
  } slot_t;

  // Configuration handed from the register file to the sequencer
  typedef struct packed {
    logic [3:0]  window_limit;
    logic [31:0] timeout_ticks;
    logic        seq_load;
    logic [30:0] seq_value;
  } cfg_t;

  // Address bits for a memory of the given depth
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Bits for a count that can reach the depth itself
  function automatic int count_w(input int depth);
    return $clog2(depth + 1);
  endfunction

endpackage

// ===== hdl/swsnd_ram.sv =====
// Slot memory of the transmit window: one write port, one registered read port.
// Depends on swsnd_pkg for the slot type and the address width.
module swsnd_ram #(
  parameter int DEPTH = swsnd_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [swsnd_pkg::addr_w(DEPTH)-1:0] wr_addr,
  input  swsnd_pkg::slot_t                    wr_data,
  input  logic [swsnd_pkg::addr_w(DEPTH)-1:0] rd_addr,
  output swsnd_pkg::slot_t                    rd_data
);

  swsnd_pkg::slot_t mem [DEPTH];

  // Write the addressed slot
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/swsnd_seq.sv =====
// Sequencer of the sliding window sender: walks the slot memory one slot a cycle,
// stalls aside, through one shared subtract-and-compare unit. Depends on swsnd_pkg.
module swsnd_seq #(
  parameter int WINDOW_MAX = swsnd_pkg::WINDOW_MAX_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  swsnd_pkg::cfg_t                          cfg,
  input  logic                                     req_valid,
  output logic                                     req_stall,
  input  swsnd_pkg::req_t                          req,
  output logic                                     rsp_valid,
  input  logic                                     rsp_stall,
  output swsnd_pkg::rsp_t                          rsp,
  output logic                                     mem_we,
  output logic [swsnd_pkg::addr_w(WINDOW_MAX)-1:0] mem_wr_addr,
  output swsnd_pkg::slot_t                         mem_wr_data,
  output logic [swsnd_pkg::addr_w(WINDOW_MAX)-1:0] mem_rd_addr,
  input  swsnd_pkg::slot_t                         mem_rd_data
);

  localparam int AW = swsnd_pkg::addr_w(WINDOW_MAX);
  localparam int CW = swsnd_pkg::count_w(WINDOW_MAX);
  localparam int LW = (CW > 4) ? CW : 4;

  swsnd_pkg::state_t state, state_next;

  logic [15:0]   handle_q;
  logic [30:0]   ack_q;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] kept;
  logic [CW-1:0] freed;
  logic [CW-1:0] in_flight;
  logic [30:0]   next_seq;
  logic [31:0]   now_ticks;
  logic          pend_valid;
  logic [30:0]   pend_seq;
  logic [15:0]   pend_payload;

  logic          accept;
  logic          out_free;
  logic          scan_end;
  logic          full;
  logic [31:0]   sub_a;
  logic [31:0]   sub_b;
  logic [31:0]   diff;
  logic          age_hit;
  logic          ack_hit;

  logic            advance;
  logic            emit;
  swsnd_pkg::rsp_t emit_val;
  logic            load_pend;
  logic            clear_pend;
  logic            count_freed;
  logic            count_kept;
  logic            send_commit;
  logic            finish_ack;

  assign req_stall = (state != swsnd_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign idx_inc   = idx + CW'(1);
  assign scan_end  = (idx == in_flight);
  assign full      = (LW'(in_flight) >= LW'(cfg.window_limit)) ||
                     (in_flight >= CW'(WINDOW_MAX));

  // Shared unit: age of a frame on a tick, sequence distance on an ack
  always_comb begin
    if (state == swsnd_pkg::S_TICK) begin
      sub_a = now_ticks;
      sub_b = mem_rd_data.stamp;
    end else begin
      sub_a = {1'b0, ack_q};
      sub_b = {1'b0, mem_rd_data.seq};
    end
    diff    = sub_a - sub_b;
    age_hit = (diff >= cfg.timeout_ticks);
    ack_hit = (diff[30:0] != 31'd0) && (diff[30:0] <= swsnd_pkg::HALF_SEQ);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      swsnd_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            swsnd_pkg::OP_SEND: state_next = swsnd_pkg::S_SEND;
            swsnd_pkg::OP_ACK:  state_next = swsnd_pkg::S_ACK;
            swsnd_pkg::OP_TICK: state_next = swsnd_pkg::S_TICK;
            default:            state_next = swsnd_pkg::S_IDLE;
          endcase
        end
      end
      swsnd_pkg::S_SEND: begin
        if (out_free) state_next = swsnd_pkg::S_IDLE;
      end
      swsnd_pkg::S_ACK: begin
        if (scan_end && out_free) state_next = swsnd_pkg::S_IDLE;
      end
      swsnd_pkg::S_TICK: begin
        if (scan_end && (!pend_valid || out_free)) state_next = swsnd_pkg::S_IDLE;
      end
      default: state_next = swsnd_pkg::S_IDLE;
    endcase
  end

  // Per-state control
  always_comb begin
    advance     = 1'b0;
    emit        = 1'b0;
    emit_val    = '0;
    load_pend   = 1'b0;
    clear_pend  = 1'b0;
    count_freed = 1'b0;
    count_kept  = 1'b0;
    send_commit = 1'b0;
    finish_ack  = 1'b0;
    mem_we      = 1'b0;
    mem_wr_addr = idx[AW-1:0];
    mem_wr_data = mem_rd_data;
    unique case (state)
      swsnd_pkg::S_IDLE: begin
      end
      swsnd_pkg::S_SEND: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_val.last = 1'b1;
          if (full) begin
            emit_val.kind = swsnd_pkg::KIND_REJECT;
          end else begin
            emit_val.kind          = swsnd_pkg::KIND_SENT;
            emit_val.frame_seq     = next_seq;
            emit_val.frame_payload = handle_q;
            send_commit            = 1'b1;
            mem_we                 = 1'b1;
            mem_wr_addr            = in_flight[AW-1:0];
            mem_wr_data.seq        = next_seq;
            mem_wr_data.payload    = handle_q;
            mem_wr_data.stamp      = now_ticks;
          end
        end
      end
      swsnd_pkg::S_ACK: begin
        if (!scan_end) begin
          // Drop acknowledged frames, pack the survivors downwards
          advance = 1'b1;
          if (ack_hit) begin
            count_freed = 1'b1;
          end else begin
            count_kept  = 1'b1;
            mem_we      = 1'b1;
            mem_wr_addr = kept[AW-1:0];
          end
        end else if (out_free) begin
          emit                 = 1'b1;
          emit_val.kind        = swsnd_pkg::KIND_ACKED;
          emit_val.freed_count = 4'(freed);
          emit_val.last        = 1'b1;
          finish_ack           = 1'b1;
        end
      end
      swsnd_pkg::S_TICK: begin
        // Hold one found frame back so the final one can carry last
        emit_val.kind          = swsnd_pkg::KIND_RESENT;
        emit_val.frame_seq     = pend_seq;
        emit_val.frame_payload = pend_payload;
        if (!scan_end) begin
          if (age_hit) begin
            if (!pend_valid || out_free) begin
              emit              = pend_valid;
              load_pend         = 1'b1;
              advance           = 1'b1;
              mem_we            = 1'b1;
              mem_wr_data.stamp = now_ticks;
            end
          end else begin
            advance = 1'b1;
          end
        end else if (pend_valid && out_free) begin
          emit          = 1'b1;
          emit_val.last = 1'b1;
          clear_pend    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Read slot 0 while idle so a new scan starts there; read ahead as the scan moves on
  assign mem_rd_addr = (state == swsnd_pkg::S_IDLE) ? '0 :
                       advance ? idx_inc[AW-1:0] : idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swsnd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      kept       <= '0;
      freed      <= '0;
      in_flight  <= '0;
      next_seq   <= swsnd_pkg::INIT_SEQ_RST;
      now_ticks  <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (state == swsnd_pkg::S_IDLE) begin
        idx   <= '0;
        kept  <= '0;
        freed <= '0;
      end else begin
        if (advance)     idx   <= idx_inc;
        if (count_kept)  kept  <= kept + CW'(1);
        if (count_freed) freed <= freed + CW'(1);
      end
      if (accept && (req.operation == swsnd_pkg::OP_TICK)) begin
        now_ticks <= now_ticks + 32'd1;
      end
      if (cfg.seq_load) begin
        next_seq <= cfg.seq_value;
      end else if (send_commit) begin
        next_seq <= next_seq + 31'd1;
      end
      if (send_commit) begin
        in_flight <= in_flight + CW'(1);
      end else if (finish_ack) begin
        in_flight <= kept;
      end
      if (load_pend) begin
        pend_valid <= 1'b1;
      end else if (clear_pend) begin
        pend_valid <= 1'b0;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      handle_q <= req.payload_handle;
      ack_q    <= req.ack_next_seq;
    end
    if (load_pend) begin
      pend_seq     <= mem_rd_data.seq;
      pend_payload <= mem_rd_data.payload;
    end
    if (emit) begin
      rsp <= emit_val;
    end
  end

endmodule

// ===== hdl/sliding_window_sender_top.sv =====
// Top level of the sliding window sender: configuration registers, slot
// memory and sequencer. Depends on swsnd_pkg, swsnd_ram and swsnd_seq.
//
//   channel   signals                          transfer when
//   req       req_valid, req_stall, req        req_valid && !req_stall
//   rsp       rsp_valid, rsp_stall, rsp        rsp_valid && !rsp_stall
//   cfg       cfg_write, cfg_index, cfg_data   cfg_write
//
// The sequencer reads one window slot per cycle from the slot memory's single
// read port as an acknowledgement or a tick scans the window, unless a
// retransmit waits on the result register; a send needs no scan.
// Reset is synchronous; afterwards the window is empty and no clearing pass runs.
// A stalled result holds in the output register; an acknowledgement or a tick
// keeps scanning meanwhile, and a tick stops its scan only when a second
// retransmit meets a full output register.
module sliding_window_sender_top #(
  parameter int WINDOW_MAX = swsnd_pkg::WINDOW_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  swsnd_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output swsnd_pkg::rsp_t rsp,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int AW = swsnd_pkg::addr_w(WINDOW_MAX);

  logic [3:0]       window_limit;
  logic [31:0]      timeout_ticks;
  swsnd_pkg::cfg_t  cfg;

  logic             mem_we;
  logic [AW-1:0]    mem_wr_addr;
  swsnd_pkg::slot_t mem_wr_data;
  logic [AW-1:0]    mem_rd_addr;
  swsnd_pkg::slot_t mem_rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit  <= swsnd_pkg::WINDOW_LIMIT_RST;
      timeout_ticks <= swsnd_pkg::TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        swsnd_pkg::REG_WINDOW_LIMIT: window_limit  <= cfg_data[3:0];
        swsnd_pkg::REG_TIMEOUT:      timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Writing the initial sequence reloads the sequence counter
  always_comb begin
    cfg.window_limit  = window_limit;
    cfg.timeout_ticks = timeout_ticks;
    cfg.seq_load      = cfg_write && (cfg_index == swsnd_pkg::REG_INIT_SEQ);
    cfg.seq_value     = cfg_data[30:0];
  end

  swsnd_ram #(
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  swsnd_seq #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mem_we      (mem_we),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule

// ===== hdl/swsnd_check.sv =====
// Port-level checks of the sliding window sender, bound to the top level.
// Depends on swsnd_pkg and sliding_window_sender_top.
module swsnd_check (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input swsnd_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input swsnd_pkg::rsp_t rsp
);

  // Reset leaves the block ready with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!req_stall && !rsp_valid))
    else $error("block not idle after reset");

  // A real request keeps the input stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (req.operation != swsnd_pkg::OP_NONE)) |=> req_stall)
    else $error("request input not stalled after a transfer");

  // Send, reject and ack results are always the final result of their request
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.kind != swsnd_pkg::KIND_RESENT)) |-> rsp.last)
    else $error("single result without last");

  // Rejects carry no frame and no freed count
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.kind == swsnd_pkg::KIND_REJECT)) |->
      ((rsp.frame_seq == 31'd0) && (rsp.frame_payload == 16'd0) &&
       (rsp.freed_count == 4'd0)))
    else $error("reject carries frame fields");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

bind sliding_window_sender_top swsnd_check u_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
